>>> sv/imtr_pkg.sv
package imtr_pkg;

  localparam int unsigned ROW_LANES = 2;
  localparam int unsigned COL_LANES = 4;
  localparam int unsigned LANES     = ROW_LANES * COL_LANES;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MUL    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 4'd1;

  // int8 saturation bounds
  localparam logic signed [ACC_W-1:0] QMAX = 32'sd127;
  localparam logic signed [ACC_W-1:0] QMIN = -32'sd128;

  typedef struct packed {
    logic [7:0]        act_row0;
    logic [7:0]        act_row1;
    logic signed [7:0] weight_col0;
    logic signed [7:0] weight_col1;
    logic signed [7:0] weight_col2;
    logic signed [7:0] weight_col3;
    logic              last_term;
  } in_t;

  typedef struct packed {
    logic signed [7:0] out_r0c0;
    logic signed [7:0] out_r0c1;
    logic signed [7:0] out_r0c2;
    logic signed [7:0] out_r0c3;
    logic signed [7:0] out_r1c0;
    logic signed [7:0] out_r1c1;
    logic signed [7:0] out_r1c2;
    logic signed [7:0] out_r1c3;
  } out_t;

endpackage

>>> sv/imtr_requant.sv
module imtr_requant (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [imtr_pkg::ACC_W-1:0]         acc_i,
  input  logic signed [imtr_pkg::SCALE_W-1:0] scale_i,
  input  logic [imtr_pkg::SHIFT_W-1:0]       shift_i,
  output logic signed [7:0]                  res_o
);
  import imtr_pkg::*;

  logic signed [ACC_W+SCALE_W-1:0] full_prod;
  logic signed [ACC_W-1:0]         prod_d, prod_q;
  logic signed [ACC_W-1:0]         shifted;

  // low 32 bits of the signed product, wrapped
  assign full_prod = $signed(acc_i) * scale_i;
  assign prod_d    = full_prod[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign shifted = prod_q >>> shift_i;

  always_comb begin
    priority if (shifted > QMAX) begin
      res_o = QMAX[7:0];
    end else if (shifted < QMIN) begin
      res_o = QMIN[7:0];
    end else begin
      res_o = shifted[7:0];
    end
  end

endmodule

>>> sv/int8_matmul_tile_requant.sv
// 2x4 int8 output-tile engine. Each input transaction carries one unsigned
// activation byte per row and one signed weight byte per column; the eight
// products are added into eight 32-bit wrapping accumulators as the
// transaction leaves the input register. A transaction with last_term set
// closes the tile: its products are included, the sums are moved out and
// the accumulators clear, so the next tile may start in the very next
// cycle. Each sum is then multiplied by scale_mul (low 32 bits kept),
// shifted right arithmetically by shift_amount and clipped to -128..127.
// Throughput is one transaction per clock while the input is not
// stalled; a result transaction passes through the input, closed-sum,
// scale multiply and output registers in turn. Backpressure on the output
// stalls the input only once every stage behind the output register is full.
// Write scale_mul (index 0) and shift_amount (index 1) only while the block
// is idle; writes to other indexes are dropped. The config port never stalls.
module int8_matmul_tile_requant (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  imtr_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output imtr_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [imtr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [imtr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import imtr_pkg::*;

  // configuration registers
  logic signed [SCALE_W-1:0] scale_q;
  logic [SHIFT_W-1:0]        shift_q;

  // stage 1: input register
  logic s1_vld_q;
  in_t  s1_q;
  // stage 2: closed tile sums
  logic                        s2_vld_q;
  logic [LANES-1:0][ACC_W-1:0] fin_q;
  // stage 3: scaled products (held inside the requant lanes)
  logic s3_vld_q;
  // output register
  logic out_vld_q;
  out_t out_q;

  logic [LANES-1:0][ACC_W-1:0] acc_q, acc_d, acc_sum;
  logic [ROW_LANES-1:0][7:0]        act;
  logic signed [COL_LANES-1:0][7:0] wgt;
  logic [LANES-1:0][7:0]            res;

  logic out_ready, s3_ready, s2_ready;
  logic s1_move, s1_ready, in_acc;
  logic s2_load, s3_load, out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      shift_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SCALE_MUL) begin
        scale_q <= cfg_data_i[SCALE_W-1:0];
      end else if (cfg_index_i == REG_SHIFT_AMOUNT) begin
        shift_q <= cfg_data_i[SHIFT_W-1:0];
      end
    end
  end

  // Ready chain from the output back: a stage may take new data when it is
  // empty or its content moves on in the same cycle.
  assign out_ready = !out_vld_q || !out_stall_i;
  assign s3_ready  = !s3_vld_q || out_ready;
  assign s2_ready  = !s2_vld_q || s3_ready;
  // Non-closing transactions only touch the accumulators and never block.
  assign s1_move   = s1_vld_q && (!s1_q.last_term || s2_ready);
  assign s1_ready  = !s1_vld_q || s1_move;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s2_load  = s1_move && s1_q.last_term;
  assign s3_load  = s2_vld_q && s3_ready;
  assign out_load = s3_vld_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_q <= in_acc;
      end
      if (s2_ready) begin
        s2_vld_q <= s2_load;
      end
      if (s3_ready) begin
        s3_vld_q <= s2_vld_q;
      end
      if (out_ready) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s2_load) begin
      fin_q <= acc_sum;
    end
  end

  // Unpack the lanes of the held transaction.
  always_comb begin
    act[0] = s1_q.act_row0;
    act[1] = s1_q.act_row1;
    wgt[0] = s1_q.weight_col0;
    wgt[1] = s1_q.weight_col1;
    wgt[2] = s1_q.weight_col2;
    wgt[3] = s1_q.weight_col3;
  end

  // Eight independent multiply-accumulates; lane r*COL_LANES+c is row r,
  // column c.
  always_comb begin
    logic signed [16:0] p;
    for (int unsigned r = 0; r < ROW_LANES; r++) begin
      for (int unsigned c = 0; c < COL_LANES; c++) begin
        p = $signed({1'b0, act[r]}) * $signed(wgt[c]);
        acc_sum[r*COL_LANES+c] = acc_q[r*COL_LANES+c] + ACC_W'(p);
      end
    end
  end

  // Advance the sums on every moving transaction; clear when the tile closes.
  always_comb begin
    acc_d = acc_q;
    if (s1_move) begin
      acc_d = s1_q.last_term ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_rq
    imtr_requant u_rq (
      .clk_i   (clk_i),
      .en_i    (s3_load),
      .acc_i   (fin_q[i]),
      .scale_i (scale_q),
      .shift_i (shift_q),
      .res_o   (res[i])
    );
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_r0c0 <= res[0];
      out_q.out_r0c1 <= res[1];
      out_q.out_r0c2 <= res[2];
      out_q.out_r0c3 <= res[3];
      out_q.out_r1c0 <= res[4];
      out_q.out_r1c1 <= res[5];
      out_q.out_r1c2 <= res[6];
      out_q.out_r1c3 <= res[7];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A non-closing transaction never creates a tile result.
  a_no_spurious_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !s1_q.last_term && !s2_vld_q |=> !s2_vld_q)
    else $error("tile result created by a non-closing transaction");

  // Closing a tile leaves the accumulators clear.
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_q.last_term |=> acc_q == '0)
    else $error("accumulators not cleared after tile close");

  // A new output only follows a filled scale stage.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s3_vld_q))
    else $error("output valid without scaled products");

endmodule
